// ===== sv/hash_slot_insert_probe_core_assert.svh =====
// Assertion macros for the hash slot insert core.
// The implication form checks the consequent in the same cycle, the next form in the cycle after.
`ifndef HASH_SLOT_INSERT_PROBE_CORE_ASSERT_SVH
`define HASH_SLOT_INSERT_PROBE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HSIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsip assertion failed");
`define HSIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsip assertion failed");
`else
`define HSIP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HSIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/hsip_pkg.sv =====
`default_nettype none
package hsip_pkg;

    localparam int TABLE_SLOTS_DEF = 101;
    // widest slot index over the supported table sizes (up to 1021 slots)
    localparam int SLOT_MAX_W      = 10;
    localparam int DIGIT_W         = 4;
    localparam int INS_W           = 7;
    localparam int TOTAL_W         = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [INS_W-1:0]   INS_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic {
        MODE_MIX  = 1'b0,
        MODE_FOLD = 1'b1
    } t_hash_mode;

    // one classified insert handed from the front end to the prober
    typedef struct packed {
        logic                     full;
        logic [DIGIT_W-1:0]       step;
        logic [SLOT_MAX_W-1:0]    home;
    } t_job;

endpackage
`default_nettype wire

// ===== sv/hsip_in_if.sv =====
`default_nettype none
interface hsip_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit_0;
    logic [3:0] digit_1;
    logic [3:0] digit_2;
    logic [3:0] digit_3;
    logic [3:0] digit_4;
    logic [3:0] digit_5;
    logic       table_full;

    modport source (output valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
                    table_full, input ready);
    modport sink   (input valid, digit_0, digit_1, digit_2, digit_3, digit_4, digit_5,
                    table_full, output ready);
endinterface
`default_nettype wire

// ===== sv/hsip_cfg_if.sv =====
`default_nettype none
interface hsip_cfg_if;
    logic valid;
    logic ready;
    logic hash_mode;

    modport source (output valid, hash_mode, input ready);
    modport sink   (input valid, hash_mode, output ready);
endinterface
`default_nettype wire

// ===== sv/hsip_out_if.sv =====
`default_nettype none
interface hsip_out_if;
    logic        valid;
    logic        ready;
    logic [6:0]  final_slot;
    logic        newly_marked;
    logic [6:0]  insert_collisions;
    logic [15:0] collision_total;

    modport source (output valid, final_slot, newly_marked, insert_collisions,
                    collision_total, input ready);
    modport sink   (input valid, final_slot, newly_marked, insert_collisions,
                    collision_total, output ready);
endinterface
`default_nettype wire

// ===== sv/hash_slot_insert_probe_core.sv =====
// Path: from input to result transaction, hash, quotient, remainder, queue push, pop,
//   one bitmap read per slot stepped over plus one for the final slot, result.
// Flow: the prober handles one insert at a time (pop, bitmap reads, result); the front
//   end runs ahead through a 2-deep queue and waits at the push while the queue is full.
// Reset: synchronous, active low; a clearing pass over all TABLE_SLOTS slots then follows,
//   during which no input transaction is taken (configuration writes still are).
`default_nettype none
module hash_slot_insert_probe_core #(
    parameter int TABLE_SLOTS = hsip_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hsip_in_if.sink     i_in,
    hsip_cfg_if.sink    i_cfg,
    hsip_out_if.source  o_out
);

    // Structure
    //   front : takes the key transaction, forms the home slot and probe step.
    //           Mode 0 mixes digits 5,1,3; mode 1 folds two three-digit halves and reduces
    //           mod 1000 first. Reduction mod TABLE_SLOTS is a reciprocal multiply: a
    //           quotient estimate, then the remainder with one corrective subtract.
    //   queue : two classified jobs, so the front end keeps hashing while the prober is busy.
    //   back  : walks the occupancy bitmap (one-bit RAM, registered read), one slot per
    //           cycle, counts collisions and marks the final slot; it also owns the
    //           clearing pass after reset and the output register.

    hsip_pkg::t_hash_mode r_hash_mode;

    hsip_pkg::t_job q_in_job;
    hsip_pkg::t_job q_out_job;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    logic           clear_done;

    // the mode register is always writable; the user is to change it only while the core is idle (not enforced here)
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_mode <= hsip_pkg::MODE_MIX;
        end else if (i_cfg.valid) begin
            r_hash_mode <= hsip_pkg::t_hash_mode'(i_cfg.hash_mode);
        end
    end

    hsip_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_hash_mode  (r_hash_mode),
        .i_clear_done (clear_done),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (q_in_job)
    );

    hsip_fifo #(
        .DEPTH (hsip_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    hsip_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (q_out_job),
        .i_empty      (q_empty),
        .o_pop        (q_pop),
        .o_clear_done (clear_done),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire

// ===== sv/hsip_ram.sv =====
`default_nettype none
module hsip_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 101
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== sv/hsip_fifo.sv =====
`default_nettype none
module hsip_fifo #(
    parameter int DEPTH = hsip_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  hsip_pkg::t_job     i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output hsip_pkg::t_job     o_job,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsip_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rptr];

    always_comb begin
        n_wptr = i_push ? wrap_inc(r_wptr) : r_wptr;
        n_rptr = i_pop  ? wrap_inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== sv/hsip_front.sv =====
`default_nettype none
module hsip_front #(
    parameter int TABLE_SLOTS = hsip_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    hsip_in_if.sink               i_in,
    input  hsip_pkg::t_hash_mode  i_hash_mode,
    input  wire logic             i_clear_done,
    input  wire logic             i_q_full,
    output logic                  o_push,
    output hsip_pkg::t_job        o_job
);

    // raw key value before reduction: up to 1665 in mix mode, below 1000 in fold mode
    localparam int VAL_W   = 11;
    localparam int MIX_W   = 12;
    localparam int PROD_W  = 2 * VAL_W;
    // floor(2^VAL_W / TABLE_SLOTS): the quotient estimate is exact or one short
    localparam logic [VAL_W-1:0] RECIP    = VAL_W'((1 << VAL_W) / TABLE_SLOTS);
    localparam logic [VAL_W-1:0] SLOTS_V  = VAL_W'(TABLE_SLOTS);
    localparam logic [MIX_W-1:0] FOLD_MOD = MIX_W'(1000);
    localparam logic [MIX_W-1:0] FOLD_2X  = MIX_W'(2000);
    localparam logic [MIX_W-1:0] K100     = MIX_W'(100);
    localparam logic [MIX_W-1:0] K10      = MIX_W'(10);
    localparam logic [hsip_pkg::DIGIT_W-1:0] FIXED_STEP = hsip_pkg::DIGIT_W'(7);

    typedef enum logic [2:0] {F_IDLE, F_HASH, F_QUO, F_REM, F_PUSH} t_fstate;

    t_fstate                    r_state, n_state;
    logic [hsip_pkg::DIGIT_W-1:0] r_dig [6];
    logic                       r_full;
    hsip_pkg::t_hash_mode       r_mode;
    logic [hsip_pkg::DIGIT_W-1:0] r_step, n_step;
    logic [VAL_W-1:0]           r_rem, n_rem;
    logic [VAL_W-1:0]           r_quo, n_quo;

    logic [MIX_W-1:0]  w_mix, w_a, w_b, w_sum, w_f1, w_fold;
    logic [PROD_W-1:0] w_est, w_back;
    logic [VAL_W-1:0]  w_diff;
    logic              w_accept;

    assign i_in.ready = (r_state == F_IDLE) && i_clear_done;
    assign w_accept   = i_in.valid && i_in.ready;

    // both hashes; the folded one is reduced mod 1000 by two compare-subtracts
    always_comb begin
        w_mix  = MIX_W'(r_dig[5]) * K100 + MIX_W'(r_dig[1]) * K10 + MIX_W'(r_dig[3]);
        w_a    = MIX_W'(r_dig[0]) * K100 + MIX_W'(r_dig[2]) * K10 + MIX_W'(r_dig[5]);
        w_b    = MIX_W'(r_dig[1]) * K100 + MIX_W'(r_dig[3]) * K10 + MIX_W'(r_dig[4]);
        w_sum  = w_a + w_b;
        w_f1   = (w_sum >= FOLD_2X) ? w_sum - FOLD_2X : w_sum;
        w_fold = (w_f1 >= FOLD_MOD) ? w_f1 - FOLD_MOD : w_f1;
    end

    // reduction mod TABLE_SLOTS: reciprocal quotient in F_QUO, remainder in the cycle after (F_REM)
    always_comb begin
        w_est  = PROD_W'(r_rem) * PROD_W'(RECIP);
        w_back = PROD_W'(r_quo) * PROD_W'(SLOTS_V);
        w_diff = r_rem - w_back[VAL_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        n_quo   = r_quo;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = F_HASH;
                end
            end
            F_HASH: begin
                n_rem   = (r_mode == hsip_pkg::MODE_MIX) ? w_mix[VAL_W-1:0]
                                                         : w_fold[VAL_W-1:0];
                n_step  = (r_mode == hsip_pkg::MODE_MIX) ? r_dig[4] : FIXED_STEP;
                n_state = F_QUO;
            end
            F_QUO: begin
                n_quo   = w_est[PROD_W-1:VAL_W];
                n_state = F_REM;
            end
            F_REM: begin
                // estimate may be one short, leaving a remainder below twice the size
                n_rem   = (w_diff >= SLOTS_V) ? w_diff - SLOTS_V : w_diff;
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_job.full = r_full;
        o_job.step = r_step;
        o_job.home = r_rem[hsip_pkg::SLOT_MAX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (w_accept) begin
            r_dig[0] <= i_in.digit_0;
            r_dig[1] <= i_in.digit_1;
            r_dig[2] <= i_in.digit_2;
            r_dig[3] <= i_in.digit_3;
            r_dig[4] <= i_in.digit_4;
            r_dig[5] <= i_in.digit_5;
            r_full   <= i_in.table_full;
            r_mode   <= i_hash_mode;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

endmodule
`default_nettype wire

// ===== sv/hsip_back.sv =====
`default_nettype none
`include "hash_slot_insert_probe_core_assert.svh"
module hsip_back #(
    parameter int TABLE_SLOTS = hsip_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  hsip_pkg::t_job  i_job,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_clear_done,
    hsip_out_if.source      o_out
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int INS_W  = hsip_pkg::INS_W;
    localparam int TOT_W  = hsip_pkg::TOTAL_W;

    typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_OUT} t_bstate;

    t_bstate                      r_state, n_state;
    logic [SLOT_W-1:0]            r_clr,   n_clr;
    logic [SLOT_W-1:0]            r_pos,   n_pos;
    logic [hsip_pkg::DIGIT_W-1:0] r_step,  n_step;
    logic                         r_full,  n_full;
    logic                         r_stop,  n_stop;
    logic                         r_fresh, n_fresh;
    logic [INS_W-1:0]             r_ins,   n_ins;
    logic [TOT_W-1:0]             r_total, n_total;
    logic                         r_valid, n_valid;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [0:0]        ram_wdata;
    logic [0:0]        ram_rdata;

    logic              w_used;
    logic [SLOT_W:0]   w_next;
    logic              w_fit;
    logic              w_move;
    logic [SLOT_W+6:0] w_slot_ext;

    hsip_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_pos),
        .o_rdata (ram_rdata)
    );

    assign w_used = ram_rdata[0];
    assign w_next = {1'b0, r_pos} + (SLOT_W + 1)'(r_step);
    assign w_fit  = w_next < (SLOT_W + 1)'(TABLE_SLOTS);
    assign w_move = w_used && w_fit && !r_full && !r_stop;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_pos     = r_pos;
        n_step    = r_step;
        n_full    = r_full;
        n_stop    = r_stop;
        n_fresh   = r_fresh;
        n_ins     = r_ins;
        n_total   = r_total;
        n_valid   = r_valid;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = 1'b0;
        unique case (r_state)
            B_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_state = B_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_pos   = i_job.home[SLOT_W-1:0];
                    n_step  = i_job.step;
                    n_full  = i_job.full;
                    n_stop  = 1'b0;
                    n_ins   = '0;
                    n_state = B_PROBE;
                end
            end
            B_PROBE: begin
                if (w_move) begin
                    // a zero step re-reads the same slot once and then ends
                    n_pos  = w_next[SLOT_W-1:0];
                    n_stop = (r_step == '0);
                    n_ins  = (r_ins == hsip_pkg::INS_MAX) ? r_ins : r_ins + 1'b1;
                    n_total = (r_total == hsip_pkg::TOTAL_MAX) ? r_total : r_total + 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = 1'b1;
                    n_fresh   = !w_used;
                    if (r_full || w_used) begin
                        n_ins   = (r_ins == hsip_pkg::INS_MAX) ? r_ins : r_ins + 1'b1;
                        n_total = (r_total == hsip_pkg::TOTAL_MAX) ? r_total
                                                                   : r_total + 1'b1;
                    end
                    n_valid = 1'b1;
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (o_out.ready) begin
                    n_valid = 1'b0;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
            r_clr   <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_total <= n_total;
            r_valid <= n_valid;
        end
        r_pos   <= n_pos;
        r_step  <= n_step;
        r_full  <= n_full;
        r_stop  <= n_stop;
        r_fresh <= n_fresh;
        r_ins   <= n_ins;
    end

    assign o_clear_done = (r_state != B_CLEAR);

    assign w_slot_ext              = (SLOT_W + 7)'(r_pos);
    assign o_out.valid             = r_valid;
    assign o_out.final_slot        = w_slot_ext[6:0];
    assign o_out.newly_marked      = r_fresh;
    assign o_out.insert_collisions = r_ins;
    assign o_out.collision_total   = r_total;

    `HSIP_ASSERT_IMPL(a_we_in_range, i_clk, i_rst_n, ram_we, ram_waddr <= SLOT_W'(TABLE_SLOTS - 1))
    `HSIP_ASSERT_IMPL(a_no_pop_in_clear, i_clk, i_rst_n, r_state == B_CLEAR, !o_pop && !r_valid)
    `HSIP_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, o_out.valid && o_out.ready, !o_out.valid)
    `HSIP_ASSERT_NEXT(a_total_holds, i_clk, i_rst_n, r_total == hsip_pkg::TOTAL_MAX, r_total == hsip_pkg::TOTAL_MAX)

endmodule
`default_nettype wire
